// File: hdl/dugc_pkg.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic gesture classifier - shared definitions
// Event and mode codes, register indexes, reset values and the fixed-point
// constants of the pulse-width to centimetre conversion.
// ----------------------------------------------------------------------------
package dugc_pkg;

    // Field widths
    localparam int ECHO_W  = 20;
    localparam int CM_W    = 8;
    localparam int EVENT_W = 4;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 3;

    // Lock modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VOL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BRIGHT = 2'd2;

    // Gesture events
    localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_NEWTAB   = 4'd1;
    localparam logic [EVENT_W-1:0] EV_CLOSE    = 4'd2;
    localparam logic [EVENT_W-1:0] EV_VOL_LOCK = 4'd3;
    localparam logic [EVENT_W-1:0] EV_VOL_UP   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_VOL_DOWN = 4'd5;
    localparam logic [EVENT_W-1:0] EV_BR_LOCK  = 4'd6;
    localparam logic [EVENT_W-1:0] EV_BR_UP    = 4'd7;
    localparam logic [EVENT_W-1:0] EV_BR_DOWN  = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE      = 3'd5;

    // Register reset values (cm)
    localparam logic [CM_W-1:0] RST_MAX_DISTANCE = 8'd60;
    localparam logic [CM_W-1:0] RST_FAR_THRESH   = 8'd45;
    localparam logic [CM_W-1:0] RST_NEAR_THRESH  = 8'd5;
    localparam logic [CM_W-1:0] RST_LOCK_LOW     = 8'd10;
    localparam logic [CM_W-1:0] RST_LOCK_HIGH    = 8'd20;
    localparam logic [CM_W-1:0] RST_RELEASE      = 8'd30;

    // cm = floor(us * 17 / 1000). Any width at or above CM_SAT_WIDTH gives
    // at least 256 cm, which always saturates. Below it the product fits in
    // 19 bits and floor(p / 1000) = (p * CM_RECIP) >> CM_SHIFT is exact
    // while p * 544 < 2^28.
    localparam int                CM_SCALE     = 17;
    localparam int                CM_SMALL_W   = 14;
    localparam int                CM_PROD_W    = 19;
    localparam logic [18:0]       CM_RECIP     = 19'd268436;
    localparam int                CM_SHIFT     = 28;
    localparam logic [ECHO_W-1:0] CM_SAT_WIDTH = 20'd15059;

endpackage

// File: hdl/dual_ultrasonic_gesture_classifier.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic gesture classifier
// Converts left/right echo widths to distances and classifies hand gestures,
// with volume and brightness lock modes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one measurement pair per item: the left and right echo
//   pulse widths in microseconds. m_ channel returns exactly one result item
//   per input item: the gesture event, both saturated distances and the lock
//   mode after that measurement.
//   The cfg_wr_* port writes the six threshold registers; write only while
//   no item is in flight.
//   The input register takes the item; when the output is free, one pass of
//   conversion (a 19x19 reciprocal multiply per side), compare and mode
//   update writes the result register, which drives m_tvalid.
//   One item is taken every cycle for as long as the receiver takes results.
//   Reset clears both stages, the lock mode to idle and the registers to
//   their defaults. When the receiver stalls, the result holds in the output
//   register and the input register still takes one more item; s_tready
//   then drops until the result is taken.
// ----------------------------------------------------------------------------
module dual_ultrasonic_gesture_classifier #(
    parameter int ECHO_BITS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // [19:0] echo_left_us, [39:20] echo_right_us
    // Result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [3:0] gesture_event, [11:4] left_cm,
                                                      // [19:12] right_cm, [21:20] mode_now
    // Configuration
    input  logic                           cfg_wr_en,
    input  logic [dugc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [dugc_pkg::CM_W-1:0]      cfg_wr_data
);
    import dugc_pkg::*;

    localparam logic [ECHO_W-1:0] ECHO_MASK =
        ECHO_W'((64'd1 << ECHO_BITS) - 64'd1);

    // Configuration registers
    logic [CM_W-1:0] max_distance_reg;
    logic [CM_W-1:0] far_threshold_reg;
    logic [CM_W-1:0] near_threshold_reg;
    logic [CM_W-1:0] lock_low_reg;
    logic [CM_W-1:0] lock_high_reg;
    logic [CM_W-1:0] release_distance_reg;

    // Pipeline registers
    logic              in_valid_reg;
    logic [ECHO_W-1:0] in_left_reg;
    logic [ECHO_W-1:0] in_right_reg;
    logic              out_valid_reg;
    logic [23:0]       out_data_reg;
    logic [MODE_W-1:0] mode_reg;

    logic               out_free;
    logic               advance;
    logic [CM_W-1:0]    left_cm;
    logic [CM_W-1:0]    right_cm;
    logic [EVENT_W-1:0] event_next;
    logic [MODE_W-1:0]  mode_next;

    function automatic logic [CM_W-1:0] echo_to_cm(input logic [ECHO_W-1:0] w,
                                                   input logic [CM_W-1:0]   ceil_cm);
        logic [CM_PROD_W-1:0]   p;
        logic [2*CM_PROD_W-1:0] prod;
        logic [CM_W-1:0]        q;
        p    = CM_PROD_W'(w[CM_SMALL_W-1:0]) * CM_PROD_W'(CM_SCALE);
        prod = (2*CM_PROD_W)'(p) * (2*CM_PROD_W)'(CM_RECIP);
        q    = CM_W'(prod >> CM_SHIFT);
        if (w >= CM_SAT_WIDTH || q > ceil_cm) begin
            return ceil_cm;
        end
        return q;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign left_cm  = echo_to_cm(in_left_reg & ECHO_MASK, max_distance_reg);
    assign right_cm = echo_to_cm(in_right_reg & ECHO_MASK, max_distance_reg);

    // Classify the measurement against the current mode
    always_comb begin
        event_next = EV_NONE;
        mode_next  = mode_reg;
        unique case (mode_reg)
            MODE_VOL: begin
                priority if (left_cm > release_distance_reg) begin
                    mode_next = MODE_IDLE;
                end else if (left_cm < lock_low_reg) begin
                    event_next = EV_VOL_UP;
                end else if (left_cm > lock_high_reg) begin
                    event_next = EV_VOL_DOWN;
                end else begin
                    event_next = EV_NONE;
                end
            end
            MODE_BRIGHT: begin
                priority if (right_cm > release_distance_reg) begin
                    mode_next = MODE_IDLE;
                end else if (right_cm < lock_low_reg) begin
                    event_next = EV_BR_UP;
                end else if (right_cm > lock_high_reg) begin
                    event_next = EV_BR_DOWN;
                end else begin
                    event_next = EV_NONE;
                end
            end
            default: begin
                // idle, and the unreachable fourth code treated as idle
                mode_next = MODE_IDLE;
                priority if (left_cm > far_threshold_reg && right_cm > far_threshold_reg &&
                             left_cm < max_distance_reg && right_cm < max_distance_reg) begin
                    event_next = EV_NEWTAB;
                end else if (left_cm <= near_threshold_reg &&
                             right_cm <= near_threshold_reg) begin
                    event_next = EV_CLOSE;
                end else if (left_cm >= lock_low_reg && left_cm <= lock_high_reg &&
                             right_cm >= release_distance_reg) begin
                    event_next = EV_VOL_LOCK;
                    mode_next  = MODE_VOL;
                end else if (right_cm >= lock_low_reg && right_cm <= lock_high_reg &&
                             left_cm >= release_distance_reg) begin
                    event_next = EV_BR_LOCK;
                    mode_next  = MODE_BRIGHT;
                end else begin
                    event_next = EV_NONE;
                end
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_distance_reg     <= RST_MAX_DISTANCE;
            far_threshold_reg    <= RST_FAR_THRESH;
            near_threshold_reg   <= RST_NEAR_THRESH;
            lock_low_reg         <= RST_LOCK_LOW;
            lock_high_reg        <= RST_LOCK_HIGH;
            release_distance_reg <= RST_RELEASE;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_MAX_DISTANCE: max_distance_reg     <= cfg_wr_data;
                REG_FAR_THRESH:   far_threshold_reg    <= cfg_wr_data;
                REG_NEAR_THRESH:  near_threshold_reg   <= cfg_wr_data;
                REG_LOCK_LOW:     lock_low_reg         <= cfg_wr_data;
                REG_LOCK_HIGH:    lock_high_reg        <= cfg_wr_data;
                REG_RELEASE:      release_distance_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_left_reg  <= s_tdata[ECHO_W-1:0];
            in_right_reg <= s_tdata[2*ECHO_W-1:ECHO_W];
        end
        if (advance) begin
            out_data_reg <= {2'b00, mode_next, right_cm, left_cm, event_next};
        end
    end

endmodule

// File: hdl/dugc_checker.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic gesture classifier - port checker
// Watches the result channel and the handshake of the top level.
// ----------------------------------------------------------------------------
module dugc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import dugc_pkg::*;

    logic [EVENT_W-1:0] ev;
    logic [MODE_W-1:0]  mode;

    assign ev   = m_tdata[3:0];
    assign mode = m_tdata[21:20];

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // An empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // Volume events only with the volume lock held
    a_vol_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ev == EV_VOL_LOCK || ev == EV_VOL_UP || ev == EV_VOL_DOWN)
        |-> mode == MODE_VOL)
        else $error("volume event outside volume lock");

    // Brightness events only with the brightness lock held
    a_br_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (ev == EV_BR_LOCK || ev == EV_BR_UP || ev == EV_BR_DOWN)
        |-> mode == MODE_BRIGHT)
        else $error("brightness event outside brightness lock");

    // Idle gestures leave the block idle, and no event code past the last
    a_idle_events: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ev <= EV_BR_DOWN &&
        ((ev != EV_NEWTAB && ev != EV_CLOSE) || mode == MODE_IDLE))
        else $error("bad event or mode after idle gesture");

endmodule

bind dual_ultrasonic_gesture_classifier dugc_checker u_dugc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture classifier stream testbench
// Sends echo-width pairs through the classifier under several threshold
// settings and idle patterns. A local model of the distance conversion and
// the lock modes predicts every result item, and each field is checked.
// ----------------------------------------------------------------------------
module tb_top;
    import dugc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 120;
    localparam int NUM_PHASES   = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CM_W-1:0]    right_cm;
        logic [CM_W-1:0]    left_cm;
        logic [EVENT_W-1:0] gesture;
    } gesture_result_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata      = '0;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CM_W-1:0]      cfg_wr_data  = '0;

    // Local copy of the threshold registers and of the lock mode
    logic [CM_W-1:0]   cfg_regs [0:5];
    logic [MODE_W-1:0] mode_track = MODE_IDLE;
    logic [MODE_W-1:0] plan_mode  = MODE_IDLE;

    logic [39:0]     pending_pairs [$];
    gesture_result_t expected_results [$];

    int          errors        = 0;
    int          send_gap_pct  = 27;
    int          recv_gap_pct  = 51;
    logic        hold_req      = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    dual_ultrasonic_gesture_classifier dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [CM_W-1:0] echo_to_cm(input logic [ECHO_W-1:0] width_us);
        logic [31:0] whole_cm;
        whole_cm = (32'(width_us) * 32'd17) / 32'd1000;
        if (whole_cm > 32'(cfg_regs[REG_MAX_DISTANCE]))
            return cfg_regs[REG_MAX_DISTANCE];
        return whole_cm[CM_W-1:0];
    endfunction

    // Step within a lock; a hand beyond the release distance gives no event
    function automatic logic [EVENT_W-1:0] lock_event(input logic [CM_W-1:0] d,
                                                      input logic [EVENT_W-1:0] ev_up,
                                                      input logic [EVENT_W-1:0] ev_down);
        if (d > cfg_regs[REG_RELEASE])
            return EV_NONE;
        if (d < cfg_regs[REG_LOCK_LOW])
            return ev_up;
        if (d > cfg_regs[REG_LOCK_HIGH])
            return ev_down;
        return EV_NONE;
    endfunction

    function automatic gesture_result_t classify(input logic [MODE_W-1:0] mode_in,
                                                 input logic [ECHO_W-1:0] wl,
                                                 input logic [ECHO_W-1:0] wr);
        gesture_result_t  res;
        logic [CM_W-1:0]  dl;
        logic [CM_W-1:0]  dr;
        dl = echo_to_cm(wl);
        dr = echo_to_cm(wr);
        res.left_cm  = dl;
        res.right_cm = dr;
        res.gesture  = EV_NONE;
        res.mode     = mode_in;
        if (mode_in == MODE_VOL) begin
            res.gesture = lock_event(dl, EV_VOL_UP, EV_VOL_DOWN);
            if (dl > cfg_regs[REG_RELEASE])
                res.mode = MODE_IDLE;
        end else if (mode_in == MODE_BRIGHT) begin
            res.gesture = lock_event(dr, EV_BR_UP, EV_BR_DOWN);
            if (dr > cfg_regs[REG_RELEASE])
                res.mode = MODE_IDLE;
        end else begin
            // any other mode value counts as idle
            res.mode = MODE_IDLE;
            if (dl > cfg_regs[REG_FAR_THRESH] && dr > cfg_regs[REG_FAR_THRESH] &&
                dl < cfg_regs[REG_MAX_DISTANCE] && dr < cfg_regs[REG_MAX_DISTANCE]) begin
                res.gesture = EV_NEWTAB;
            end else if (dl <= cfg_regs[REG_NEAR_THRESH] &&
                         dr <= cfg_regs[REG_NEAR_THRESH]) begin
                res.gesture = EV_CLOSE;
            end else if (dl >= cfg_regs[REG_LOCK_LOW] && dl <= cfg_regs[REG_LOCK_HIGH] &&
                         dr >= cfg_regs[REG_RELEASE]) begin
                res.gesture = EV_VOL_LOCK;
                res.mode    = MODE_VOL;
            end else if (dr >= cfg_regs[REG_LOCK_LOW] && dr <= cfg_regs[REG_LOCK_HIGH] &&
                         dl >= cfg_regs[REG_RELEASE]) begin
                res.gesture = EV_BR_LOCK;
                res.mode    = MODE_BRIGHT;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int clip8(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    function automatic int near_cm(input logic [CM_W-1:0] t);
        return clip8(int'(t) + int'($urandom_range(4)) - 2);
    endfunction

    // Any pulse width that converts to exactly this many cm before saturation
    function automatic logic [ECHO_W-1:0] cm_width(input int cm);
        int lo;
        int hi;
        lo = (cm * 1000 + 16) / 17;
        hi = ((cm + 1) * 1000 + 16) / 17 - 1;
        return ECHO_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [ECHO_W-1:0] noise_width();
        if ($urandom_range(1) == 0)
            return ECHO_W'($urandom);
        return ECHO_W'($urandom_range(20000));
    endfunction

    // Queue a pair and advance the planned mode so later items can steer
    task automatic push_pair(input logic [ECHO_W-1:0] wl, input logic [ECHO_W-1:0] wr);
        gesture_result_t res;
        res = classify(plan_mode, wl, wr);
        plan_mode = res.mode;
        pending_pairs.push_back({wr, wl});
    endtask

    task automatic push_cm(input int l, input int r);
        push_pair(cm_width(l), cm_width(r));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CM_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        cfg_regs[idx] = val;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic load_thresholds(input int mx, input int far, input int near,
                                   input int lo, input int hi, input int rel);
        write_reg(REG_MAX_DISTANCE, CM_W'(mx));
        write_reg(REG_FAR_THRESH,   CM_W'(far));
        write_reg(REG_NEAR_THRESH,  CM_W'(near));
        write_reg(REG_LOCK_LOW,     CM_W'(lo));
        write_reg(REG_LOCK_HIGH,    CM_W'(hi));
        write_reg(REG_RELEASE,      CM_W'(rel));
    endtask

    task automatic random_phase(input int n);
        int pick;
        int dl;
        int dr;
        int d_lock;
        logic [ECHO_W-1:0] wl;
        logic [ECHO_W-1:0] wr;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            dl   = $urandom_range(255);
            dr   = $urandom_range(255);
            if (plan_mode == MODE_VOL || plan_mode == MODE_BRIGHT) begin
                if (pick < 15)
                    d_lock = near_cm(cfg_regs[REG_RELEASE]);
                else if (pick < 45)
                    d_lock = near_cm(cfg_regs[REG_LOCK_LOW]);
                else if (pick < 75)
                    d_lock = near_cm(cfg_regs[REG_LOCK_HIGH]);
                else
                    d_lock = $urandom_range(clip8(int'(cfg_regs[REG_RELEASE]) + 1));
                if (plan_mode == MODE_VOL)
                    dl = d_lock;
                else
                    dr = d_lock;
            end else if (pick < 12) begin
                dl = $urandom_range(int'(cfg_regs[REG_MAX_DISTANCE]),
                                    int'(cfg_regs[REG_FAR_THRESH]));
                dr = $urandom_range(int'(cfg_regs[REG_MAX_DISTANCE]),
                                    int'(cfg_regs[REG_FAR_THRESH]));
            end else if (pick < 22) begin
                dl = $urandom_range(clip8(int'(cfg_regs[REG_NEAR_THRESH]) + 1));
                dr = $urandom_range(clip8(int'(cfg_regs[REG_NEAR_THRESH]) + 1));
            end else if (pick < 56) begin
                dl = $urandom_range(clip8(int'(cfg_regs[REG_LOCK_HIGH]) + 1),
                                    clip8(int'(cfg_regs[REG_LOCK_LOW]) - 1));
                dr = (pick < 40) ? near_cm(cfg_regs[REG_RELEASE])
                                 : $urandom_range(255, int'(cfg_regs[REG_RELEASE]));
            end else if (pick < 90) begin
                dr = $urandom_range(clip8(int'(cfg_regs[REG_LOCK_HIGH]) + 1),
                                    clip8(int'(cfg_regs[REG_LOCK_LOW]) - 1));
                dl = (pick < 74) ? near_cm(cfg_regs[REG_RELEASE])
                                 : $urandom_range(255, int'(cfg_regs[REG_RELEASE]));
            end
            wl = cm_width(dl);
            wr = cm_width(dr);
            if ($urandom_range(99) < 10)
                wl = noise_width();
            if ($urandom_range(99) < 10)
                wr = noise_width();
            push_pair(wl, wr);
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued pairs, predict on acceptance
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_pairs
        gesture_result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                res = classify(mode_track, s_tdata[19:0], s_tdata[39:20]);
                mode_track = res.mode;
                expected_results.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_tdata  <= pending_pairs.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        gesture_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("gesture_event", int'(want.gesture),  int'(m_tdata[3:0]));
                    check_field("left_cm",       int'(want.left_cm),  int'(m_tdata[11:4]));
                    check_field("right_cm",      int'(want.right_cm), int'(m_tdata[19:12]));
                    check_field("mode_now",      int'(want.mode),     int'(m_tdata[21:20]));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int mx;
        int far;
        int near;
        int lo;
        int hi;
        int rel;
        cfg_regs[REG_MAX_DISTANCE] = RST_MAX_DISTANCE;
        cfg_regs[REG_FAR_THRESH]   = RST_FAR_THRESH;
        cfg_regs[REG_NEAR_THRESH]  = RST_NEAR_THRESH;
        cfg_regs[REG_LOCK_LOW]     = RST_LOCK_LOW;
        cfg_regs[REG_LOCK_HIGH]    = RST_LOCK_HIGH;
        cfg_regs[REG_RELEASE]      = RST_RELEASE;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items on the reset thresholds
        push_pair(20'h00000, 20'h00000);
        push_pair(20'hFFFFF, 20'hFFFFF);
        push_cm(50, 50);
        push_cm(5, 5);
        push_cm(6, 5);
        push_cm(10, 30);
        push_cm(9, 0);
        push_cm(21, 0);
        push_cm(15, 59);
        push_cm(30, 0);
        push_cm(31, 0);
        push_cm(30, 20);
        push_cm(0, 9);
        push_cm(0, 25);
        push_cm(40, 15);
        push_cm(0, 31);
        push_cm(46, 59);
        push_cm(45, 50);
        push_pair(20'h55555, 20'hAAAAA);
        push_pair(20'hAAAAA, 20'h55555);
        push_pair(20'd588, 20'd589);
        push_pair(20'd15058, 20'd15059);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_thresholds(0, 0, 0, 0, 0, 0);
                1: load_thresholds(255, 255, 255, 255, 255, 255);
                2: load_thresholds(255, 0, 0, 0, 255, 0);
                3: load_thresholds(1, 255, 0, 255, 0, 255);
                default: begin
                    if ($urandom_range(99) < 70) begin
                        near = $urandom_range(10);
                        lo   = near + $urandom_range(10, 1);
                        hi   = lo + $urandom_range(15);
                        rel  = hi + $urandom_range(20, 1);
                        far  = rel + $urandom_range(20);
                        mx   = clip8(far + $urandom_range(60, 2));
                    end else begin
                        // contradictory orderings allowed
                        mx   = $urandom_range(255, 1);
                        far  = $urandom_range(255);
                        near = $urandom_range(255);
                        lo   = $urandom_range(255);
                        hi   = $urandom_range(255);
                        rel  = $urandom_range(255);
                    end
                    load_thresholds(mx, far, near, lo, hi, rel);
                end
            endcase
            if (p < 4) begin
                send_gap_pct <= 27;
                recv_gap_pct <= 51;
            end else if (p < 8) begin
                send_gap_pct <= 51;
                recv_gap_pct <= 27;
            end else begin
                send_gap_pct <= 0;
                recv_gap_pct <= 0;
            end
            random_phase(PHASE_ITEMS);
            if (p == 8) begin
                // stall the receiver while the sender keeps offering
                @(posedge aclk);
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
